// ===== rtl/pmcas_pkg.sv =====
`default_nettype none

package pmcas_pkg;

    // Mesh geometry
    localparam int MESH_MAX   = 32;
    localparam int COORD_W    = $clog2(MESH_MAX);
    localparam int MSIZE_W    = 6;
    localparam int MESH_DEPTH = 2 * MESH_MAX * MESH_MAX * MESH_MAX;
    localparam int MESH_AW    = $clog2(MESH_DEPTH);
    localparam int SUM_W      = 48;

    // Assignment order
    localparam int MAX_ORDER  = 4;
    localparam int ORD_W      = 3;
    localparam int OIDX_W     = 2;

    // Weight table
    localparam int INTERP_HALF_BINS = 1024;
    localparam int TAB_ROWS   = 2 * INTERP_HALF_BINS + 1;
    localparam int TAB_COLS   = 4;
    localparam int TAB_DEPTH  = TAB_ROWS * TAB_COLS;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int ROW_W      = $clog2(2 * INTERP_HALF_BINS);
    localparam int WT_W       = 24;

    // Locate arithmetic
    localparam int NMP_W      = 26;
    localparam int REM_W      = MSIZE_W;
    localparam int MCNT_W     = $clog2(NMP_W);
    localparam int T_W        = 41;
    localparam int LO_W       = 20;

    // Input kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PART = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_MESH_SIZE = 2'd0;
    localparam logic [1:0] CFG_ORDER     = 2'd1;
    localparam logic [1:0] CFG_INV_SPACE = 2'd2;
    localparam logic [1:0] CFG_INTERLACE = 2'd3;

    typedef logic [COORD_W-1:0]       coord_t;
    typedef logic signed [NMP_W-1:0]  nmp_t;

endpackage

`default_nettype wire

// ===== rtl/pmcas_ram.sv =====
`default_nettype none

module pmcas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pmcas_mod.sv =====
`default_nettype none

module pmcas_mod import pmcas_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MSIZE_W-1:0] modulus,
    input  wire nmp_t [2:0]         value,
    output logic                    done,
    output coord_t [2:0]            base
);

    logic [NMP_W-1:0]  mag_reg [3];
    logic              neg_reg [3];
    logic [REM_W-1:0]  rem_reg [3];
    logic [REM_W-1:0]  rem_next [3];
    logic [REM_W-1:0]  trial [3];
    logic [REM_W-1:0]  diff [3];
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // One remainder bit per cycle for each axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i]    = {rem_reg[i][REM_W-2:0], mag_reg[i][NMP_W-1]};
            rem_next[i] = (trial[i] >= modulus) ? REM_W'(trial[i] - modulus) : trial[i];
            diff[i]     = REM_W'(modulus - rem_reg[i]);
            base[i]     = (neg_reg[i] && rem_reg[i] != '0) ? diff[i][COORD_W-1:0]
                                                            : rem_reg[i][COORD_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCNT_W'(NMP_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Magnitude shift and remainder
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (start)
            begin
                neg_reg[i] <= value[i][NMP_W-1];
                mag_reg[i] <= value[i][NMP_W-1] ? NMP_W'(-value[i]) : NMP_W'(value[i]);
                rem_reg[i] <= '0;
            end
            else if (busy_reg)
            begin
                mag_reg[i] <= {mag_reg[i][NMP_W-2:0], 1'b0};
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/pm_charge_assign_scatter.sv =====
`default_nettype none

// Particle-mesh charge scatter with a table-driven B-spline weight.
// Input channel (s_axis): tuser selects the beat kind: table load, particle,
// or mesh cell read. Output channel (m_axis): one beat per touched cell for a
// particle (order^3 beats, tlast on the final one), one beat for a mesh read,
// none for a table load.
// Configuration: cfg_we/cfg_index/cfg_data write mesh_size, order,
// inv_spacing and interlace_half; write them only while the block is idle.
// Reset: control and configuration registers go to their defaults and the
// charge mesh, all 65536 cells, is swept to zero, one cell per cycle, before
// s_axis_tready first rises. Steps: a table load is written as it is accepted;
// a mesh read waits in ST_RDW for the registered memory output. A particle
// takes three position multiplies, a 26-step serial modulo for the wrap, 12
// table reads, then per cell two partial products on the shared multiplier
// and one read-modify-write of the mesh memory port.
// Stall: a result waits in the output register; the block holds its work
// until that register is free, and takes the next input beat while the final
// result still waits.
module pm_charge_assign_scatter import pmcas_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, charge, table_row, table_col, table_value,
    // cell_x, cell_y, cell_z, cell_plane, zero fill
    input  wire logic [183:0] s_axis_tdata,
    // kind
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_weight, out_x, out_y, out_z, mesh_value, zero fill
    output logic [111:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDW   = 4'd2;
    localparam logic [3:0] ST_LMUL  = 4'd3;
    localparam logic [3:0] ST_LPOS  = 4'd4;
    localparam logic [3:0] ST_MOD   = 4'd5;
    localparam logic [3:0] ST_FETCH = 4'd6;
    localparam logic [3:0] ST_T0M   = 4'd7;
    localparam logic [3:0] ST_T0R   = 4'd8;
    localparam logic [3:0] ST_T1L   = 4'd9;
    localparam logic [3:0] ST_T1H   = 4'd10;
    localparam logic [3:0] ST_T1R   = 4'd11;
    localparam logic [3:0] ST_WL    = 4'd12;
    localparam logic [3:0] ST_WH    = 4'd13;
    localparam logic [3:0] ST_WR    = 4'd14;
    localparam logic [3:0] ST_WB    = 4'd15;

    localparam logic [3:0] FETCH_END = 4'd12;

    // Configuration
    logic [MSIZE_W-1:0] mesh_size_reg;
    logic [ORD_W-1:0]   order_reg;
    logic [31:0]        inv_spacing_reg;
    logic               interlace_reg;
    logic [MSIZE_W-1:0] m_eff;
    logic [ORD_W-1:0]   o_eff;
    logic [OIDX_W-1:0]  o_m1;
    logic               shift1;

    // Input unpack
    logic [1:0]         in_kind;
    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_charge;
    logic [11:0]        in_row;
    logic [1:0]         in_col;
    logic [WT_W-1:0]    in_value;
    coord_t             in_cx;
    coord_t             in_cy;
    coord_t             in_cz;
    logic               in_plane;
    logic               in_acc;

    // Control
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [MESH_AW-1:0] clr_cnt_reg;
    logic [1:0]         axis_reg;
    logic [3:0]         fcnt_reg;
    logic [3:0]         cap_idx;
    logic [OIDX_W-1:0]  a_reg;
    logic [OIDX_W-1:0]  b_reg;
    logic [OIDX_W-1:0]  c_reg;
    logic               mod_start_reg;
    logic               mod_done;
    coord_t [2:0]       mod_base;

    // Datapath
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] charge_reg;
    nmp_t [2:0]         nmp_reg;
    logic [ROW_W-1:0]   row_reg [3];
    logic signed [WT_W-1:0] wt_reg [3][TAB_COLS];
    logic [T_W-1:0]     t0_reg;
    logic [T_W-1:0]     t1_reg;
    logic [T_W-1:0]     w_reg;
    coord_t             cx_reg;
    coord_t             cy_reg;
    coord_t             cz_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        lo_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic [63:0]        t0_sum;
    logic [65:0]        split_sum;
    logic [55:0]        p_val;
    logic [57:0]        p2;
    logic [SUM_W:0]     sum49;
    logic [SUM_W-1:0]   sum_sat;
    logic [MESH_AW-1:0] cell_addr;
    logic               last_cell;

    // Output register
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_w_reg;
    coord_t             out_x_reg;
    coord_t             out_y_reg;
    coord_t             out_z_reg;
    logic [SUM_W-1:0]   out_mesh_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               out_load;

    // Memory ports
    logic               mesh_we;
    logic [MESH_AW-1:0] mesh_waddr;
    logic [SUM_W-1:0]   mesh_wdata;
    logic               mesh_re;
    logic [MESH_AW-1:0] mesh_raddr;
    logic [SUM_W-1:0]   mesh_rdata;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr;
    logic               tab_re;
    logic [TAB_AW-1:0]  tab_raddr;
    logic [WT_W-1:0]    tab_rdata;

    // Unpack the input beat
    assign in_kind   = s_axis_tuser;
    assign in_pos[0] = s_axis_tdata[31:0];
    assign in_pos[1] = s_axis_tdata[63:32];
    assign in_pos[2] = s_axis_tdata[95:64];
    assign in_charge = s_axis_tdata[127:96];
    assign in_row    = s_axis_tdata[139:128];
    assign in_col    = s_axis_tdata[141:140];
    assign in_value  = s_axis_tdata[165:142];
    assign in_cx     = s_axis_tdata[170:166];
    assign in_cy     = s_axis_tdata[175:171];
    assign in_cz     = s_axis_tdata[180:176];
    assign in_plane  = s_axis_tdata[181];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Clamp mesh size and order
    always_comb
    begin
        if (mesh_size_reg == '0)
            m_eff = MSIZE_W'(1);
        else if (mesh_size_reg > MSIZE_W'(MESH_MAX))
            m_eff = MSIZE_W'(MESH_MAX);
        else
            m_eff = mesh_size_reg;
        if (order_reg == '0)
            o_eff = ORD_W'(1);
        else if (order_reg > ORD_W'(MAX_ORDER))
            o_eff = ORD_W'(MAX_ORDER);
        else
            o_eff = order_reg;
    end

    assign o_m1   = OIDX_W'(o_eff - ORD_W'(1));
    assign shift1 = (o_eff >= ORD_W'(3));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_size_reg   <= MSIZE_W'(32);
            order_reg       <= ORD_W'(4);
            inv_spacing_reg <= 32'd16777216;
            interlace_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MESH_SIZE: mesh_size_reg   <= cfg_data[MSIZE_W-1:0];
                CFG_ORDER:     order_reg       <= cfg_data[ORD_W-1:0];
                CFG_INV_SPACE: inv_spacing_reg <= cfg_data;
                CFG_INTERLACE: interlace_reg   <= cfg_data[0];
            endcase
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LMUL:
            begin
                mul_a = {pos_reg[axis_reg][31], pos_reg[axis_reg]};
                mul_b = {1'b0, inv_spacing_reg};
            end
            ST_T0M:
            begin
                mul_a = {charge_reg[31], charge_reg};
                mul_b = {{9{wt_reg[0][a_reg][WT_W-1]}}, wt_reg[0][a_reg]};
            end
            ST_T1L:
            begin
                mul_a = {13'd0, t0_reg[LO_W-1:0]};
                mul_b = {{9{wt_reg[1][b_reg][WT_W-1]}}, wt_reg[1][b_reg]};
            end
            ST_T1H:
            begin
                mul_a = {{12{t0_reg[T_W-1]}}, t0_reg[T_W-1:LO_W]};
                mul_b = {{9{wt_reg[1][b_reg][WT_W-1]}}, wt_reg[1][b_reg]};
            end
            ST_WL:
            begin
                mul_a = {13'd0, t1_reg[LO_W-1:0]};
                mul_b = {{9{wt_reg[2][c_reg][WT_W-1]}}, wt_reg[2][c_reg]};
            end
            ST_WH:
            begin
                mul_a = {{12{t1_reg[T_W-1]}}, t1_reg[T_W-1:LO_W]};
                mul_b = {{9{wt_reg[2][c_reg][WT_W-1]}}, wt_reg[2][c_reg]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Rounding of the products
    assign t0_sum    = prod_reg + 64'd16384;
    assign split_sum = {prod_reg[45:0], 20'd0} + {{2{lo_reg[63]}}, lo_reg} + 66'd4194304;

    // Scaled position, nearest point and fraction
    assign p_val = prod_reg[63:8];
    assign p2    = {{2{p_val[55]}}, p_val} - {25'd0, shift1, 32'd0}
                   + {26'd0, interlace_reg, 31'd0} + 58'h0_0000_8000_0000;

    // Saturating accumulate
    assign sum49 = {mesh_rdata[SUM_W-1], mesh_rdata} + {{8{w_reg[T_W-1]}}, w_reg};
    always_comb
    begin
        if (sum49[SUM_W] != sum49[SUM_W-1])
            sum_sat = sum49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum49[SUM_W-1:0];
    end

    assign cell_addr = {interlace_reg, cx_reg, cy_reg, cz_reg};
    assign last_cell = (a_reg == o_m1) && (b_reg == o_m1) && (c_reg == o_m1);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_load  = ((state_reg == ST_RDW) || (state_reg == ST_WB)) && out_free;
    assign cap_idx   = fcnt_reg - 4'd1;

    // Memory port selection
    always_comb
    begin
        mesh_we    = 1'b0;
        mesh_waddr = cell_addr;
        mesh_wdata = sum_sat;
        mesh_re    = 1'b0;
        mesh_raddr = cell_addr;
        if (state_reg == ST_CLR)
        begin
            mesh_we    = 1'b1;
            mesh_waddr = clr_cnt_reg;
            mesh_wdata = '0;
        end
        else if (state_reg == ST_WB && out_free)
        begin
            mesh_we = 1'b1;
        end
        if (in_acc && in_kind == KIND_READ)
        begin
            mesh_re    = 1'b1;
            mesh_raddr = {in_plane, in_cx, in_cy, in_cz};
        end
        else if (state_reg == ST_WL)
        begin
            mesh_re = 1'b1;
        end
    end

    assign tab_we    = in_acc && (in_kind == KIND_LOAD) && (in_row <= 12'(2 * INTERP_HALF_BINS));
    assign tab_waddr = TAB_AW'({in_row, in_col});
    assign tab_re    = (state_reg == ST_FETCH) && (fcnt_reg < FETCH_END);
    assign tab_raddr = TAB_AW'({row_reg[fcnt_reg[3:2]], fcnt_reg[1:0]});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:   if (clr_cnt_reg == '1) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_acc && in_kind == KIND_PART)
                    state_next = ST_LMUL;
                else if (in_acc && in_kind == KIND_READ)
                    state_next = ST_RDW;
            end
            ST_RDW:   if (out_free) state_next = ST_IDLE;
            ST_LMUL:  state_next = ST_LPOS;
            ST_LPOS:  state_next = (axis_reg == 2'd2) ? ST_MOD : ST_LMUL;
            ST_MOD:   if (mod_done) state_next = ST_FETCH;
            ST_FETCH: if (fcnt_reg == FETCH_END) state_next = ST_T0M;
            ST_T0M:   state_next = ST_T0R;
            ST_T0R:   state_next = ST_T1L;
            ST_T1L:   state_next = ST_T1H;
            ST_T1H:   state_next = ST_T1R;
            ST_T1R:   state_next = ST_WL;
            ST_WL:    state_next = ST_WH;
            ST_WH:    state_next = ST_WR;
            ST_WR:    state_next = ST_WB;
            ST_WB:
            begin
                if (out_free)
                begin
                    priority if (c_reg != o_m1)
                        state_next = ST_WL;
                    else if (b_reg != o_m1)
                        state_next = ST_T1L;
                    else if (a_reg != o_m1)
                        state_next = ST_T0M;
                    else
                        state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            axis_reg      <= '0;
            fcnt_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            mod_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_start_reg <= (state_reg == ST_LPOS) && (axis_reg == 2'd2);
            if (state_reg == ST_CLR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (in_acc)
                axis_reg <= '0;
            else if (state_reg == ST_LPOS)
                axis_reg <= axis_reg + 1'b1;
            if (state_reg == ST_MOD)
                fcnt_reg <= '0;
            else if (state_reg == ST_FETCH)
                fcnt_reg <= fcnt_reg + 1'b1;
            // Advance the cell loop: z inner, x outer
            if (state_reg == ST_FETCH)
            begin
                a_reg <= '0;
                b_reg <= '0;
                c_reg <= '0;
            end
            else if (state_reg == ST_WB && out_free)
            begin
                if (c_reg != o_m1)
                    c_reg <= c_reg + 1'b1;
                else
                begin
                    c_reg <= '0;
                    if (b_reg != o_m1)
                        b_reg <= b_reg + 1'b1;
                    else
                    begin
                        b_reg <= '0;
                        a_reg <= a_reg + 1'b1;
                    end
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod[63:0];
        if (state_reg == ST_T1L || state_reg == ST_WL)
            lo_reg <= prod[63:0];
        if (in_acc && in_kind == KIND_PART)
        begin
            pos_reg[0] <= in_pos[0];
            pos_reg[1] <= in_pos[1];
            pos_reg[2] <= in_pos[2];
            charge_reg <= in_charge;
        end
        if (state_reg == ST_LPOS)
        begin
            nmp_reg[axis_reg] <= p2[57:32];
            row_reg[axis_reg] <= p2[31:32-ROW_W];
        end
        if (state_reg == ST_FETCH && fcnt_reg != '0)
            wt_reg[cap_idx[3:2]][cap_idx[1:0]] <= tab_rdata;
        if (state_reg == ST_T0R)
            t0_reg <= t0_sum[55:15];
        if (state_reg == ST_T1R)
            t1_reg <= split_sum[63:23];
        if (state_reg == ST_WR)
            w_reg <= split_sum[63:23];
        // Cell coordinates: take a mesh read's cell, or load the base, then step with periodic wrap
        if (in_acc && in_kind == KIND_READ)
        begin
            cx_reg <= in_cx;
            cy_reg <= in_cy;
            cz_reg <= in_cz;
        end
        else if (state_reg == ST_FETCH)
        begin
            cx_reg <= mod_base[0];
            cy_reg <= mod_base[1];
            cz_reg <= mod_base[2];
        end
        else if (state_reg == ST_WB && out_free)
        begin
            if (c_reg != o_m1)
                cz_reg <= ({1'b0, cz_reg} + 1'b1 == m_eff) ? '0 : cz_reg + 1'b1;
            else
            begin
                cz_reg <= mod_base[2];
                if (b_reg != o_m1)
                    cy_reg <= ({1'b0, cy_reg} + 1'b1 == m_eff) ? '0 : cy_reg + 1'b1;
                else
                begin
                    cy_reg <= mod_base[1];
                    cx_reg <= ({1'b0, cx_reg} + 1'b1 == m_eff) ? '0 : cx_reg + 1'b1;
                end
            end
        end
        // Load the output beat
        if (out_load)
        begin
            out_x_reg <= cx_reg;
            out_y_reg <= cy_reg;
            out_z_reg <= cz_reg;
            if (state_reg == ST_RDW)
            begin
                out_w_reg    <= '0;
                out_mesh_reg <= mesh_rdata;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_w_reg    <= {{(SUM_W-T_W){w_reg[T_W-1]}}, w_reg};
                out_mesh_reg <= sum_sat;
                out_last_reg <= last_cell;
            end
        end
    end

    pmcas_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start_reg),
        .modulus (m_eff),
        .value   (nmp_reg),
        .done    (mod_done),
        .base    (mod_base)
    );

    pmcas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MESH_DEPTH)
    ) u_mesh (
        .clk   (clk),
        .we    (mesh_we),
        .waddr (mesh_waddr),
        .wdata (mesh_wdata),
        .re    (mesh_re),
        .raddr (mesh_raddr),
        .rdata (mesh_rdata)
    );

    pmcas_ram #(
        .WIDTH (WT_W),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (in_value),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_mesh_reg, out_z_reg, out_y_reg, out_x_reg, out_w_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // Never overwrite a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output beat overwritten");

    // Modulo result only arrives while the sequencer waits for it
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("modulo done outside wait state");

    // Every cell update emits a beat in the same cycle
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && mesh_we) |-> out_load)
        else $error("mesh update without output beat");

    // No input beat during the clearing sweep
    a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> !s_axis_tready)
        else $error("input accepted during clear");
`endif

endmodule

`default_nettype wire
